// ----- design/crcn_pkg.sv -----
package crcn_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int RADIUS_WIDTH = 12;
	localparam int SIZE_WIDTH = 15;
	localparam int NORM_WIDTH = 16;
	localparam int NORM_ONE = 16384;
	localparam int SQ_WIDTH = 2 * RADIUS_WIDTH;
	localparam int D2_WIDTH = SQ_WIDTH + 1;
	localparam int ROOT_BITS = 16;
	localparam int PROD_WIDTH = ROOT_BITS + D2_WIDTH + 1;
	localparam int RES_WIDTH = 60;
	localparam int SCALE_SHIFT = 30;

	typedef struct packed {
		logic [RES_WIDTH-1:0] rem;
		logic [PROD_WIDTH-1:0] prod;
		logic [ROOT_BITS-1:0] root;
		logic neg;
	} lane_t;

	typedef struct packed {
		logic valid;
		logic hit;
		logic zero;
		logic [D2_WIDTH-1:0] d2;
		lane_t lx;
		lane_t ly;
	} pipe_t;

endpackage

// ----- design/crcn_cell.sv -----
module crcn_cell #(
	parameter int BIT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  crcn_pkg::pipe_t din,
	output crcn_pkg::pipe_t dout
);

	function automatic crcn_pkg::lane_t step(input crcn_pkg::lane_t l,
			input logic [crcn_pkg::D2_WIDTH-1:0] d2);
		logic [crcn_pkg::RES_WIDTH-1:0] trial;
		crcn_pkg::lane_t o;
		trial = (crcn_pkg::RES_WIDTH'(l.prod) << (BIT + 1))
			+ (crcn_pkg::RES_WIDTH'(d2) << (2 * BIT));
		o = l;
		if (trial <= l.rem) begin
			o.rem = l.rem - trial;
			o.prod = l.prod + (crcn_pkg::PROD_WIDTH'(d2) << BIT);
			o.root = l.root | (crcn_pkg::ROOT_BITS'(1) << BIT);
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout.valid <= din.valid;
			dout.hit <= din.hit;
			dout.zero <= din.zero;
			dout.d2 <= din.d2;
			dout.lx <= step(din.lx, din.d2);
			dout.ly <= step(din.ly, din.d2);
		end
	end

endmodule

// ----- design/crcn_front.sv -----
module crcn_front #(
	parameter int COORD_WIDTH = crcn_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  logic signed [COORD_WIDTH-1:0] circle_x,
	input  logic signed [COORD_WIDTH-1:0] circle_y,
	input  logic [crcn_pkg::RADIUS_WIDTH-1:0] radius,
	input  logic signed [COORD_WIDTH-1:0] box_x,
	input  logic signed [COORD_WIDTH-1:0] box_y,
	input  logic [crcn_pkg::SIZE_WIDTH-1:0] box_width,
	input  logic [crcn_pkg::SIZE_WIDTH-1:0] box_height,
	output crcn_pkg::pipe_t dout
);

	localparam int EW = ((COORD_WIDTH > crcn_pkg::SIZE_WIDTH) ? COORD_WIDTH
		: crcn_pkg::SIZE_WIDTH) + 3;
	localparam int RW = crcn_pkg::RADIUS_WIDTH;

	logic signed [EW-1:0] dx, dy;
	logic far_x, far_y;

	function automatic logic signed [EW-1:0] offset(input logic signed [COORD_WIDTH-1:0] c,
			input logic signed [COORD_WIDTH-1:0] lo, input logic [crcn_pkg::SIZE_WIDTH-1:0] sz);
		logic signed [EW-1:0] ce, le, he, cl;
		ce = EW'(c);
		le = EW'(lo);
		he = le + EW'(signed'({1'b0, sz}));
		if (ce < le) cl = le;
		else if (ce > he) cl = he;
		else cl = ce;
		return ce - cl;
	endfunction

	function automatic logic is_far(input logic signed [EW-1:0] d,
			input logic [RW-1:0] r);
		logic signed [EW-1:0] re;
		re = EW'(signed'({1'b0, r}));
		return (d > re) || (-d > re);
	endfunction

	always_comb begin
		dx = offset(circle_x, box_x, box_width);
		dy = offset(circle_y, box_y, box_height);
		far_x = is_far(dx, radius);
		far_y = is_far(dy, radius);
	end

	logic valid_s1, valid_s2;
	logic far_s1, far_s2;
	logic negx_s1, negy_s1, negx_s2, negy_s2;
	logic [RW-1:0] magx_s1, magy_s1, r_s1;
	logic [crcn_pkg::SQ_WIDTH-1:0] sqx_s2, sqy_s2, r2_s2;
	logic [crcn_pkg::D2_WIDTH-1:0] d2;

	always_ff @(posedge clk) begin
		far_s1 <= far_x || far_y;
		negx_s1 <= dx[EW-1];
		negy_s1 <= dy[EW-1];
		magx_s1 <= dx[EW-1] ? RW'(-dx) : RW'(dx);
		magy_s1 <= dy[EW-1] ? RW'(-dy) : RW'(dy);
		r_s1 <= radius;
		far_s2 <= far_s1;
		negx_s2 <= negx_s1;
		negy_s2 <= negy_s1;
		sqx_s2 <= magx_s1 * magx_s1;
		sqy_s2 <= magy_s1 * magy_s1;
		r2_s2 <= r_s1 * r_s1;
	end

	assign d2 = crcn_pkg::D2_WIDTH'(sqx_s2) + crcn_pkg::D2_WIDTH'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			dout <= '0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			dout.valid <= valid_s2;
			dout.hit <= !far_s2 && (d2 <= crcn_pkg::D2_WIDTH'(r2_s2));
			dout.zero <= (d2 == '0);
			dout.d2 <= d2;
			dout.lx.rem <= crcn_pkg::RES_WIDTH'(sqx_s2) << crcn_pkg::SCALE_SHIFT;
			dout.lx.prod <= '0;
			dout.lx.root <= '0;
			dout.lx.neg <= negx_s2;
			dout.ly.rem <= crcn_pkg::RES_WIDTH'(sqy_s2) << crcn_pkg::SCALE_SHIFT;
			dout.ly.prod <= '0;
			dout.ly.root <= '0;
			dout.ly.neg <= negy_s2;
		end
	end

endmodule

// ----- design/circle_rect_collision_normal_core.sv -----
// Circle against axis-aligned rectangle test with unit contact normal.
// Input: drive the circle and rectangle fields with start high; a
// transaction is taken at each rising edge where start is high and busy
// is low. busy stays low, so a new transaction may enter every cycle.
// Output: done pulses for one cycle with hit, normal_x and normal_y
// (Q1.14). With no hit the normal is zero; a centre inside or on the
// rectangle gives (0, -1).
// Pipeline: three front stages form the offsets, squares and hit
// decision; a row of 16 root cells settles one bit of each normal
// magnitude per cycle; one stage rounds and signs.
// Throughput: one transaction per cycle, set by the cell row, which hands
// every partial result to its neighbour each cycle.
// Reset: arst_n clears every valid flag; transactions in flight are lost
// and done stays low until fresh ones arrive.
// The receiver cannot stall: each result shows for exactly one cycle.
module circle_rect_collision_normal_core #(
	parameter int COORD_WIDTH = crcn_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [COORD_WIDTH-1:0] circle_x,
	input  logic signed [COORD_WIDTH-1:0] circle_y,
	input  logic [crcn_pkg::RADIUS_WIDTH-1:0] radius,
	input  logic signed [COORD_WIDTH-1:0] box_x,
	input  logic signed [COORD_WIDTH-1:0] box_y,
	input  logic [crcn_pkg::SIZE_WIDTH-1:0] box_width,
	input  logic [crcn_pkg::SIZE_WIDTH-1:0] box_height,
	output logic done,
	output logic hit,
	output logic signed [crcn_pkg::NORM_WIDTH-1:0] normal_x,
	output logic signed [crcn_pkg::NORM_WIDTH-1:0] normal_y
);

	localparam int NB = crcn_pkg::ROOT_BITS;
	localparam int NW = crcn_pkg::NORM_WIDTH;

	crcn_pkg::pipe_t row [NB+1];

	assign busy = 1'b0;

	crcn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(start && !busy),
		.circle_x(circle_x),
		.circle_y(circle_y),
		.radius(radius),
		.box_x(box_x),
		.box_y(box_y),
		.box_width(box_width),
		.box_height(box_height),
		.dout(row[0])
	);

	for (genvar i = 0; i < NB; i++) begin : g_cell
		crcn_cell #(.BIT(NB - 1 - i)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.din(row[i]),
			.dout(row[i+1])
		);
	end

	function automatic logic [NW-1:0] finish(input crcn_pkg::lane_t l);
		logic [NB:0] rounded;
		logic [NW-1:0] m;
		rounded = ({1'b0, l.root} + (NB+1)'(1)) >> 1;
		m = NW'(rounded);
		return l.neg ? -m : m;
	endfunction

	crcn_pkg::pipe_t last;
	assign last = row[NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		hit <= last.hit;
		if (!last.hit) begin
			normal_x <= '0;
			normal_y <= '0;
		end else if (last.zero) begin
			normal_x <= '0;
			normal_y <= -NW'(crcn_pkg::NORM_ONE);
		end else begin
			normal_x <= finish(last.lx);
			normal_y <= finish(last.ly);
		end
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	localparam int CW = crcn_pkg::COORD_WIDTH_DEF;
	localparam int RWD = crcn_pkg::RADIUS_WIDTH;
	localparam int SWD = crcn_pkg::SIZE_WIDTH;
	localparam int NWD = crcn_pkg::NORM_WIDTH;

	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [RWD-1:0] r;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic [SWD-1:0] bw;
		logic [SWD-1:0] bh;
	} probe_t;

	typedef struct packed {
		logic hit;
		logic signed [NWD-1:0] nx;
		logic signed [NWD-1:0] ny;
	} contact_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CW-1:0] circle_x = '0, circle_y = '0, box_x = '0, box_y = '0;
	logic [RWD-1:0] radius = '0;
	logic [SWD-1:0] box_width = '0, box_height = '0;
	logic done, hit;
	logic signed [NWD-1:0] normal_x, normal_y;

	probe_t pending_probes[$];
	contact_t expected_contacts[$];
	int mismatches = 0;
	int burst_left = 0;
	int gap_left = 0;
	bit hold_for_drain = 1'b0;
	bit stimulus_done = 1'b0;
	probe_t driven;
	logic busy_sampled = 1'b0;
	int sent = 0;
	bit drain_done = 1'b0;

	circle_rect_collision_normal_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.circle_x(circle_x), .circle_y(circle_y), .radius(radius),
		.box_x(box_x), .box_y(box_y), .box_width(box_width), .box_height(box_height),
		.done(done), .hit(hit), .normal_x(normal_x), .normal_y(normal_y)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned unit_component(longint unsigned mag,
			longint unsigned d2);
		longint unsigned rhs, lo, hi, mid, t;
		rhs = 4 * mag * mag * (64'd1 << 28);
		lo = 0;
		hi = crcn_pkg::NORM_ONE;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			t = 2 * mid - 1;
			if (t * t * d2 <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic logic signed [NWD-1:0] signed_unit(longint d,
			longint unsigned d2);
		longint unsigned n;
		n = unit_component(d < 0 ? -d : d, d2);
		return d < 0 ? -n[NWD-1:0] : n[NWD-1:0];
	endfunction

	function automatic contact_t predict_contact(probe_t p);
		contact_t c;
		longint px, py, dx, dy, r, hx, hy;
		longint unsigned d2;
		c = '0;
		r = p.r;
		px = p.cx;
		py = p.cy;
		hx = longint'(p.bx) + longint'(p.bw);
		hy = longint'(p.by) + longint'(p.bh);
		if (px < p.bx) px = p.bx;
		else if (px > hx) px = hx;
		if (py < p.by) py = p.by;
		else if (py > hy) py = hy;
		dx = p.cx - px;
		dy = p.cy - py;
		if (dx > r || -dx > r || dy > r || -dy > r)
			return c;
		d2 = dx * dx + dy * dy;
		if (d2 > r * r)
			return c;
		c.hit = 1'b1;
		if (d2 == 0) begin
			c.ny = -NWD'(crcn_pkg::NORM_ONE);
		end else begin
			c.nx = signed_unit(dx, d2);
			c.ny = signed_unit(dy, d2);
		end
		return c;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	function automatic probe_t random_probe();
		probe_t p;
		int mode;
		p.cx = CW'($urandom);
		p.cy = CW'($urandom);
		p.r = RWD'($urandom);
		p.bx = CW'($urandom);
		p.by = CW'($urandom);
		p.bw = SWD'($urandom);
		p.bh = SWD'($urandom);
		mode = $urandom_range(0, 9);
		if (mode < 8) begin
			// place the centre near the box so hits and edge contacts are common
			p.bw = (mode < 4) ? SWD'($urandom_range(0, 2000)) : p.bw;
			p.bh = (mode < 4) ? SWD'($urandom_range(0, 2000)) : p.bh;
			p.bx = CW'($urandom_range(0, 40000) - 20000);
			p.by = CW'($urandom_range(0, 40000) - 20000);
			p.r = (mode == 7) ? '0 : RWD'($urandom_range(0, 4095));
			p.cx = CW'(p.bx + $signed($urandom_range(0, p.bw + 2 * p.r + 64))
				- p.r - 32);
			p.cy = CW'(p.by + $signed($urandom_range(0, p.bh + 2 * p.r + 64))
				- p.r - 32);
		end
		return p;
	endfunction

	task automatic add_probe(int cx, int cy, int r, int bx, int by, int bw, int bh);
		probe_t p;
		p.cx = CW'(cx); p.cy = CW'(cy); p.r = RWD'(r);
		p.bx = CW'(bx); p.by = CW'(by); p.bw = SWD'(bw); p.bh = SWD'(bh);
		pending_probes.push_back(p);
	endtask

	initial begin
		add_probe(0, 0, 0, 0, 0, 0, 0);
		add_probe(100, 100, 10, 0, 0, 200, 200);
		add_probe(-50, 50, 50, 0, 0, 100, 100);
		add_probe(-51, 50, 50, 0, 0, 100, 100);
		add_probe(-30, -40, 50, 0, 0, 100, 100);
		add_probe(130, 140, 50, 0, 0, 100, 100);
		add_probe(50, 150, 50, 0, 0, 100, 100);
		add_probe(-1, 0, 0, 0, 0, 10, 10);
		add_probe(32767, 32767, 4095, 32767, 32767, 32767, 32767);
		add_probe(-32768, -32768, 4095, -32768, -32768, 0, 0);
		add_probe(-32768, 32767, 4095, 32767, -32768, 32767, 32767);
		add_probe(32767, -32768, 4095, -32768, 32767, 0, 0);
		add_probe(-32768, -32768, 4095, 32767, 32767, 32767, 32767);
		add_probe(-4095, -4095, 4095, 0, 0, 32767, 32767);
		add_probe(-2896, -2896, 4095, 0, 0, 32767, 32767);
		add_probe(1, -4095, 4095, 0, 0, 0, 0);
		add_probe(-4095, 1, 4095, 0, 0, 0, 0);
		add_probe(10, 20, 4095, 10, 20, 0, 0);
		for (int i = 0; i < 600; i++)
			pending_probes.push_back(random_probe());
		stimulus_done = 1'b1;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy_sampled) begin
				expected_contacts.push_back(predict_contact(driven));
				sent++;
			end
			if (sent == 300 && !drain_done) begin
				hold_for_drain = 1'b1;
				drain_done = 1'b1;
			end
			if (hold_for_drain && expected_contacts.size() == 0)
				hold_for_drain = 1'b0;
			if (start && busy_sampled) begin
				// keep the current transaction on the ports
			end else if (hold_for_drain || pending_probes.size() == 0) begin
				start <= 1'b0;
			end else if (burst_left == 0 && gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
				burst_left--;
				driven = pending_probes.pop_front();
				start <= 1'b1;
				circle_x <= driven.cx;
				circle_y <= driven.cy;
				radius <= driven.r;
				box_x <= driven.bx;
				box_y <= driven.by;
				box_width <= driven.bw;
				box_height <= driven.bh;
			end
		end
	end

	// busy seen at the accepting edge decides whether the transaction went in
	always @(posedge clk)
		busy_sampled <= busy;

	// monitor
	always @(posedge clk) begin
		contact_t want;
		if (arst_n && done) begin
			if (expected_contacts.size() == 0) begin
				$display("mismatch: result with no transaction outstanding");
				mismatches++;
			end else begin
				want = expected_contacts.pop_front();
				if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
				if (normal_x !== want.nx) report_mismatch("normal_x", normal_x, want.nx);
				if (normal_y !== want.ny) report_mismatch("normal_y", normal_y, want.ny);
			end
		end
	end

	initial begin
		wait (stimulus_done && arst_n);
		wait (pending_probes.size() == 0 && !start);
		wait (expected_contacts.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("** circle_rect_collision_normal_core: PASSED **");
		else
			$display("** circle_rect_collision_normal_core: FAILED **");
		$finish;
	end

	initial begin
		#2000000;
		$display("** circle_rect_collision_normal_core: FAILED **");
		$finish;
	end
endmodule
